### rtl/core/srb_pkg.sv
// Shared types and constants for the rotating sprite blitter.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none

package srb_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_SPRITE_W_DEF = 64;
  localparam int unsigned MAX_SPRITE_H_DEF = 64;
  localparam int unsigned SCREEN_W_DEF     = 320;
  localparam int unsigned SCREEN_H_DEF     = 200;

  // Depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Datapath widths fixed by the field widths.
  localparam int unsigned PROD_W     = 24;  // 16-bit Q1.14 times 8-bit half-pixel offset
  localparam int unsigned SUM_W      = 27;  // two products plus the centre bias
  localparam int unsigned IDX_W      = 7;   // source column or row, below the 7-bit size
  localparam int unsigned TEX_ADDR_W = 16;  // covers the largest sprite memory
  localparam int unsigned FB_ADDR_W  = 16;
  localparam int unsigned COLOR_W    = 8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SPRITE_W = 3'd0,
    REG_SPRITE_H = 3'd1,
    REG_COS      = 3'd2,
    REG_SIN      = 3'd3,
    REG_POS_X    = 3'd4,
    REG_POS_Y    = 3'd5
  } srb_reg_e;

  // One classified operation handed from the front end to the back end.
  typedef struct packed {
    logic                  is_load;
    logic                  store_en;
    logic                  draw_en;
    logic [TEX_ADDR_W-1:0] tex_addr;
    logic [COLOR_W-1:0]    color;
    logic [FB_ADDR_W-1:0]  fb_addr;
  } srb_op_t;

endpackage

`default_nettype wire

### rtl/core/sprite_rotate_blit_unit.sv
// An input transfer loads the first of five registers on its way to the result: three front
// stages, the queue, the memory read.
// Throughput: one item per cycle, loads and renders alike, set by one texel memory port,
// while the output is not stalled.
// Reset clears the configuration to its defaults and empties every stage and the queue.
// Sprite memory is not cleared and holds no valid data until loaded.
// Top level of the rotating sprite blitter; uses srb_pkg, srb_front, srb_queue, srb_back.
`default_nettype none

module sprite_rotate_blit_unit import srb_pkg::*; #(
  parameter int unsigned MAX_SPRITE_W = MAX_SPRITE_W_DEF,
  parameter int unsigned MAX_SPRITE_H = MAX_SPRITE_H_DEF,
  parameter int unsigned SCREEN_W     = SCREEN_W_DEF,
  parameter int unsigned SCREEN_H     = SCREEN_H_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // col [5:0], row [11:6], texel_color [19:12]
  input  wire logic        s_axis_tuser,   // kind [0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // fb_address [15:0], pixel_color [23:16]
  output logic             m_axis_tuser    // write_enable [0]
);

  logic    fr_valid, fr_ready, bk_valid, bk_ready;
  srb_op_t fr_op, bk_op;
  logic    out_we;
  logic [FB_ADDR_W-1:0] out_fb;
  logic [COLOR_W-1:0]   out_color;

  assign cfg_ready_o = 1'b1;

  srb_front #(
    .MAX_SPRITE_W(MAX_SPRITE_W),
    .MAX_SPRITE_H(MAX_SPRITE_H),
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_col_i   (s_axis_tdata[5:0]),
    .in_row_i   (s_axis_tdata[11:6]),
    .in_color_i (s_axis_tdata[19:12]),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready),
    .op_o       (fr_op)
  );

  srb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i (fr_op),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (bk_op)
  );

  srb_back #(
    .MAX_SPRITE_W(MAX_SPRITE_W),
    .MAX_SPRITE_H(MAX_SPRITE_H)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (bk_valid),
    .op_ready_o   (bk_ready),
    .op_i         (bk_op),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_we_o     (out_we),
    .out_fb_addr_o(out_fb),
    .out_color_o  (out_color)
  );

  assign m_axis_tdata = {out_color, out_fb};
  assign m_axis_tuser = out_we;

endmodule

`default_nettype wire

### rtl/core/srb_front.sv
// Front end of the sprite blitter: configuration registers, inverse rotation and
// classification of each item into a queue operation. Depends on srb_pkg.
`default_nettype none

module srb_front import srb_pkg::*; #(
  parameter int unsigned MAX_SPRITE_W = MAX_SPRITE_W_DEF,
  parameter int unsigned MAX_SPRITE_H = MAX_SPRITE_H_DEF,
  parameter int unsigned SCREEN_W     = SCREEN_W_DEF,
  parameter int unsigned SCREEN_H     = SCREEN_H_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        in_kind_i,
  input  wire logic [5:0]  in_col_i,
  input  wire logic [5:0]  in_row_i,
  input  wire logic [7:0]  in_color_i,
  output logic             op_valid_o,
  input  wire logic        op_ready_i,
  output srb_op_t          op_o
);

  // Configuration registers.
  logic [6:0]         width_q, height_q;
  logic signed [15:0] cos_q, sin_q;
  logic [8:0]         pos_x_q;
  logic [7:0]         pos_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd32;
      height_q <= 7'd32;
      cos_q    <= 16'sd16384;
      sin_q    <= 16'sd0;
      pos_x_q  <= 9'd0;
      pos_y_q  <= 8'd0;
    end else if (cfg_valid_i) begin
      unique case (srb_reg_e'(cfg_index_i))
        REG_SPRITE_W: width_q  <= cfg_data_i[6:0];
        REG_SPRITE_H: height_q <= cfg_data_i[6:0];
        REG_COS:      cos_q    <= $signed(cfg_data_i);
        REG_SIN:      sin_q    <= $signed(cfg_data_i);
        REG_POS_X:    pos_x_q  <= cfg_data_i[8:0];
        REG_POS_Y:    pos_y_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage moves when the one after it has room.
  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c      = !vc_q || op_ready_i;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;
  assign op_valid_o = vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  // Stage A: offsets from the centre in half pixels and the four products.
  logic signed [7:0]        dx2, dy2;
  logic [9:0]               fx;
  logic [8:0]               fy;
  logic signed [PROD_W-1:0] pcx_d, psy_d, pcy_d, psx_d;

  assign dx2   = $signed({1'b0, in_col_i, 1'b0}) - $signed({1'b0, width_q});
  assign dy2   = $signed({1'b0, in_row_i, 1'b0}) - $signed({1'b0, height_q});
  assign pcx_d = cos_q * dx2;
  assign psy_d = sin_q * dy2;
  assign pcy_d = cos_q * dy2;
  assign psx_d = sin_q * dx2;
  assign fx    = 10'(pos_x_q) + 10'(in_col_i);
  assign fy    = 9'(pos_y_q) + 9'(in_row_i);

  logic                     a_kind_q, a_in_box_q, a_on_screen_q;
  logic [5:0]               a_col_q, a_row_q;
  logic [7:0]               a_color_q;
  logic [9:0]               a_fx_q;
  logic [8:0]               a_fy_q;
  logic signed [PROD_W-1:0] pcx_q, psy_q, pcy_q, psx_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_kind_q      <= in_kind_i;
      a_col_q       <= in_col_i;
      a_row_q       <= in_row_i;
      a_color_q     <= in_color_i;
      a_in_box_q    <= (7'(in_col_i) < width_q) && (7'(in_row_i) < height_q);
      a_on_screen_q <= (32'(fx) < SCREEN_W) && (32'(fy) < SCREEN_H);
      a_fx_q        <= fx;
      a_fy_q        <= fy;
      pcx_q         <= pcx_d;
      psy_q         <= psy_d;
      pcy_q         <= pcy_d;
      psx_q         <= psx_d;
    end
  end

  // Stage B: source position in 1/32768 pixel, truncated toward zero.
  logic signed [SUM_W-1:0] bias_x, bias_y, sum_x, sum_y;
  logic [SUM_W-17:0]       sxv, syv;
  logic                    x_ok, y_ok;
  logic [IDX_W-1:0]        idx_x, idx_y;
  logic                    store_ok;

  assign bias_x = $signed({{(SUM_W-22){1'b0}}, 8'({1'b0, width_q}) + 8'd1, 14'd0});
  assign bias_y = $signed({{(SUM_W-22){1'b0}}, 8'({1'b0, height_q}) + 8'd1, 14'd0});
  assign sum_x  = SUM_W'(pcx_q) + SUM_W'(psy_q) + bias_x;
  assign sum_y  = SUM_W'(pcy_q) - SUM_W'(psx_q) + bias_y;
  assign sxv    = sum_x[SUM_W-2:15];
  assign syv    = sum_y[SUM_W-2:15];

  // A negative sum truncates to source zero only when it lies within one pixel of zero.
  always_comb begin
    if (sum_x[SUM_W-1]) begin
      x_ok = (&sum_x[SUM_W-1:15]) && (|sum_x[14:0]) && (width_q != 7'd0);
    end else begin
      x_ok = (32'(sxv) < 32'(width_q)) && (32'(sxv) < MAX_SPRITE_W);
    end
    if (sum_y[SUM_W-1]) begin
      y_ok = (&sum_y[SUM_W-1:15]) && (|sum_y[14:0]) && (height_q != 7'd0);
    end else begin
      y_ok = (32'(syv) < 32'(height_q)) && (32'(syv) < MAX_SPRITE_H);
    end
  end

  always_comb begin
    if (a_kind_q) begin
      idx_x = sum_x[SUM_W-1] ? '0 : sxv[IDX_W-1:0];
      idx_y = sum_y[SUM_W-1] ? '0 : syv[IDX_W-1:0];
    end else begin
      idx_x = IDX_W'(a_col_q);
      idx_y = IDX_W'(a_row_q);
    end
  end

  assign store_ok = (32'(a_col_q) < MAX_SPRITE_W) && (32'(a_row_q) < MAX_SPRITE_H);

  logic             b_load_q, b_store_q, b_draw_q;
  logic [IDX_W-1:0] b_idx_x_q, b_idx_y_q;
  logic [7:0]       b_color_q;
  logic [9:0]       b_fx_q;
  logic [8:0]       b_fy_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      b_load_q  <= !a_kind_q;
      b_store_q <= !a_kind_q && store_ok;
      b_draw_q  <= a_kind_q && a_in_box_q && x_ok && y_ok && a_on_screen_q;
      b_idx_x_q <= idx_x;
      b_idx_y_q <= idx_y;
      b_color_q <= a_color_q;
      b_fx_q    <= a_fx_q;
      b_fy_q    <= a_fy_q;
    end
  end

  // Stage C: linear texel and framebuffer addresses.
  srb_op_t op_d, op_q;

  always_comb begin
    op_d.is_load  = b_load_q;
    op_d.store_en = b_store_q;
    op_d.draw_en  = b_draw_q;
    op_d.tex_addr = TEX_ADDR_W'(32'(b_idx_y_q) * MAX_SPRITE_W + 32'(b_idx_x_q));
    op_d.color    = b_color_q;
    op_d.fb_addr  = FB_ADDR_W'(32'(b_fy_q) * SCREEN_W + 32'(b_fx_q));
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

`default_nettype wire

### rtl/core/srb_queue.sv
// Short first-in first-out queue of classified operations between the front
// and back ends of the sprite blitter. Depends on srb_pkg.
`default_nettype none

module srb_queue import srb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  srb_op_t   push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output srb_op_t   pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  srb_op_t            entry_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (32'(count_q) < DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/srb_back.sv
// Back end of the sprite blitter: sprite texel memory, texel lookup and the
// result register with its handshake. Depends on srb_pkg.
`default_nettype none

module srb_back import srb_pkg::*; #(
  parameter int unsigned MAX_SPRITE_W = MAX_SPRITE_W_DEF,
  parameter int unsigned MAX_SPRITE_H = MAX_SPRITE_H_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              op_valid_i,
  output logic                   op_ready_o,
  input  srb_op_t                op_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   out_we_o,
  output logic [FB_ADDR_W-1:0]   out_fb_addr_o,
  output logic [COLOR_W-1:0]     out_color_o
);

  localparam int unsigned DEPTH  = MAX_SPRITE_W * MAX_SPRITE_H;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [COLOR_W-1:0]   mem_q [DEPTH];
  logic [COLOR_W-1:0]   rdata_q;
  logic                 out_valid_q, draw_q;
  logic [FB_ADDR_W-1:0] fb_q;
  logic                 take;
  logic [ADDR_W-1:0]    addr;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign take       = op_valid_i && op_ready_o;
  assign addr       = op_i.tex_addr[ADDR_W-1:0];

  // Loads and renders leave the queue in order, so a render always sees earlier loads.
  always_ff @(posedge clk_i) begin
    if (take && op_i.is_load && op_i.store_en) begin
      mem_q[addr] <= op_i.color;
    end
    if (take && !op_i.is_load) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_ready_o) begin
      out_valid_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      draw_q <= !op_i.is_load && op_i.draw_en;
      fb_q   <= op_i.fb_addr;
    end
  end

  // Colour zero is the transparent key.
  assign out_valid_o   = out_valid_q;
  assign out_we_o      = draw_q && (rdata_q != '0);
  assign out_fb_addr_o = out_we_o ? fb_q : '0;
  assign out_color_o   = out_we_o ? rdata_q : '0;

endmodule

`default_nettype wire

### rtl/core/srb_checker.sv
// Port-level checks for the rotating sprite blitter, bound to the top level.
// Sees only the top-level ports; depends on srb_pkg for its defaults.
`default_nettype none

module srb_checker import srb_pkg::*; #(
  parameter int unsigned SCREEN_W = SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = SCREEN_H_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A stalled result must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Without a framebuffer write the address and colour are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("non-zero payload on a suppressed write");

  // A transparent texel never reaches the framebuffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:16] != 8'd0)
    else $error("transparent colour written");

  // A write lands on screen; checked only when the screen fits the 16-bit address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (SCREEN_W * SCREEN_H > 65536) || (32'(m_axis_tdata[15:0]) < SCREEN_W * SCREEN_H))
    else $error("framebuffer address off screen");

endmodule

bind sprite_rotate_blit_unit srb_checker #(
  .SCREEN_W(SCREEN_W),
  .SCREEN_H(SCREEN_H)
) u_srb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
